### hw/rtl/acv_pkg.sv
// Package for the artifact container validator.
// Holds the layout constants, status codes and register indexes.
// No dependencies.
package acv_pkg;

  localparam int HDR_BYTES    = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 296;

  // verdict status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_CONTAINER = 4'd3;
  localparam logic [3:0] ST_TYPE      = 4'd4;
  localparam logic [3:0] ST_VERSION   = 4'd5;
  localparam logic [3:0] ST_KEY       = 4'd6;
  localparam logic [3:0] ST_SIZE      = 4'd7;
  localparam logic [3:0] ST_TABLE     = 4'd8;
  localparam logic [3:0] ST_RANGE     = 4'd9;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MAGIC     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CONTAINER = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TYPE      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_VERSION   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY       = 3'd4;

  // last header byte of each header field (byte position within file)
  localparam logic [4:0] HP_MAGIC     = 5'd3;
  localparam logic [4:0] HP_CONTAINER = 5'd5;
  localparam logic [4:0] HP_TYPE      = 5'd7;
  localparam logic [4:0] HP_VERSION   = 5'd11;
  localparam logic [4:0] HP_SECTIONS  = 5'd15;
  localparam logic [4:0] HP_KEY       = 5'd23;
  localparam logic [4:0] HP_FSIZE     = 5'd31;

  // entry byte index after the last byte of each entry field
  localparam logic [4:0] EP_TYPE   = 5'd4;
  localparam logic [4:0] EP_FLAGS  = 5'd8;
  localparam logic [4:0] EP_OFFSET = 5'd16;
  localparam logic [4:0] EP_SIZE   = 5'd24;
  localparam logic [4:0] EP_COUNT  = 5'd28;
  localparam logic [4:0] EP_STRIDE = 5'd0;

  typedef struct packed {
    logic        kind;
    logic [31:0] section_total;
    logic [3:0]  status;
    logic [31:0] elem_stride;
    logic [31:0] elem_count;
    logic [63:0] sec_size;
    logic [63:0] sec_offset;
    logic [31:0] sec_flags;
    logic [31:0] sec_type;
  } result_t;

endpackage

### hw/rtl/artifact_container_validator.sv
// Artifact container validator, top level.
// Depends on acv_pkg for layout constants, status codes and the result type.
//
// Checks a container file streamed in one byte per request, least significant
// byte of each field first, with tlast on the final byte. The 32-byte header
// (magic, container version, type, artifact version, section count, cache key,
// file size) is compared against the configuration registers; then the
// 32-byte section entries (type, flags, offset, size, element count, stride)
// are parsed, and each entry that passes its range check produces a
// descriptor (tuser = 0) as long as no error has been seen and the table fits
// the declared file size. The last byte produces one verdict (tuser = 1)
// carrying the foremost failing check and the header's section count; then all
// stream state returns to its reset value, configuration is kept. Bytes after
// the table are only counted. The byte counter saturates at its top value.
// Throughput is one byte per cycle: each byte is handled by one pass of
// logic between the stream state registers and a two-entry result buffer
// (output register plus skid), and s_axis_tready drops only while both
// entries hold results. Results are registered (in the skid while the output
// register is held). Write configuration only while the block is idle.
module artifact_container_validator
  import acv_pkg::*;
#(
  parameter int COUNT_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input byte stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,   // is_last
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] sec_type, [63:32] sec_flags, [127:64] sec_offset,
  // [191:128] sec_size, [223:192] elem_count, [255:224] elem_stride,
  // [259:256] status, [291:260] section_total, [295:292] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser    // result_kind
);

  // configuration registers
  logic [31:0] exp_magic;
  logic [15:0] exp_container;
  logic [15:0] exp_type;
  logic [31:0] exp_version;
  logic [63:0] exp_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_magic     <= '0;
      exp_container <= '0;
      exp_type      <= '0;
      exp_version   <= '0;
      exp_key       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAGIC:     exp_magic     <= cfg_wdata[31:0];
        REG_CONTAINER: exp_container <= cfg_wdata[15:0];
        REG_TYPE:      exp_type      <= cfg_wdata[15:0];
        REG_VERSION:   exp_version   <= cfg_wdata[31:0];
        REG_KEY:       exp_key       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stream state
  logic [COUNT_WIDTH-1:0] byte_count, byte_count_next;
  logic [63:0] field_shift, field_shift_next;
  logic [63:0] hdr_fsize, hdr_fsize_next;
  logic [31:0] hdr_sections, hdr_sections_next;
  logic [31:0] sections_left, sections_left_next;
  logic [4:0]  entry_idx, entry_idx_next;
  logic [31:0] cur_type, cur_type_next;
  logic [31:0] cur_flags, cur_flags_next;
  logic [63:0] cur_offset, cur_offset_next;
  logic [63:0] cur_size, cur_size_next;
  logic [31:0] cur_count, cur_count_next;
  logic [63:0] table_end, table_end_next;
  logic [3:0]  first_error, first_error_next;

  logic        accept;
  logic        in_header;
  logic        have_desc;
  logic        range_bad;
  logic        table_bad;
  logic        push;
  logic [63:0] fsize_room;
  result_t     res;
  logic [3:0]  verdict;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_header = (byte_count < COUNT_WIDTH'(HDR_BYTES));

  // entry range check against header values (stable during the table)
  assign range_bad = (cur_offset < table_end) || (cur_offset > hdr_fsize) ||
                     (cur_size > (hdr_fsize - cur_offset));

  // table must fit in the declared file size
  assign fsize_room = hdr_fsize_next - 64'(HDR_BYTES);
  assign table_bad  = (hdr_fsize_next < 64'(HDR_BYTES)) ||
                      ({32'd0, hdr_sections_next} > {5'd0, fsize_room[63:5]});

  always_comb begin
    byte_count_next    = byte_count;
    field_shift_next   = {s_axis_tdata, field_shift[63:8]};
    hdr_fsize_next     = hdr_fsize;
    hdr_sections_next  = hdr_sections;
    sections_left_next = sections_left;
    entry_idx_next     = entry_idx;
    cur_type_next      = cur_type;
    cur_flags_next     = cur_flags;
    cur_offset_next    = cur_offset;
    cur_size_next      = cur_size;
    cur_count_next     = cur_count;
    table_end_next     = table_end;
    first_error_next   = first_error;
    have_desc          = 1'b0;

    if (byte_count != '1) byte_count_next = byte_count + COUNT_WIDTH'(1);

    if (in_header) begin
      unique case (byte_count[4:0])
        HP_MAGIC:
          if (field_shift_next[63:32] != exp_magic && first_error == ST_OK)
            first_error_next = ST_MAGIC;
        HP_CONTAINER:
          if (field_shift_next[63:48] != exp_container && first_error == ST_OK)
            first_error_next = ST_CONTAINER;
        HP_TYPE:
          if (exp_type != '0 && field_shift_next[63:48] != exp_type &&
              first_error == ST_OK)
            first_error_next = ST_TYPE;
        HP_VERSION:
          if (field_shift_next[63:32] != exp_version && first_error == ST_OK)
            first_error_next = ST_VERSION;
        HP_SECTIONS: begin
          hdr_sections_next  = field_shift_next[63:32];
          sections_left_next = field_shift_next[63:32];
          table_end_next     = 64'(HDR_BYTES) + {27'd0, field_shift_next[63:32], 5'd0};
        end
        HP_KEY:
          if (field_shift_next != exp_key && first_error == ST_OK)
            first_error_next = ST_KEY;
        HP_FSIZE:
          hdr_fsize_next = field_shift_next;
        default: ;
      endcase
    end else if (sections_left != '0) begin
      entry_idx_next = entry_idx + 5'd1;
      unique case (entry_idx_next)
        EP_TYPE:   cur_type_next   = field_shift_next[63:32];
        EP_FLAGS:  cur_flags_next  = field_shift_next[63:32];
        EP_OFFSET: cur_offset_next = field_shift_next;
        EP_SIZE:   cur_size_next   = field_shift_next;
        EP_COUNT:  cur_count_next  = field_shift_next[63:32];
        EP_STRIDE: begin
          sections_left_next = sections_left - 32'd1;
          if (range_bad) begin
            if (first_error == ST_OK) first_error_next = ST_RANGE;
          end else if (first_error == ST_OK && !table_bad) begin
            have_desc = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // verdict priority: short, header mismatch, file size, table, then range
    if (byte_count < COUNT_WIDTH'(HDR_BYTES - 1))
      verdict = ST_SHORT;
    else if (first_error_next >= ST_MAGIC && first_error_next <= ST_KEY)
      verdict = first_error_next;
    else if (hdr_fsize_next != 64'(byte_count_next))
      verdict = ST_SIZE;
    else if (table_bad)
      verdict = ST_TABLE;
    else
      verdict = first_error_next;

    res = '0;
    if (s_axis_tlast) begin
      res.kind          = 1'b1;
      res.status        = verdict;
      res.section_total = hdr_sections_next;
    end else begin
      res.kind        = 1'b0;
      res.sec_type    = cur_type_next;
      res.sec_flags   = cur_flags_next;
      res.sec_offset  = cur_offset_next;
      res.sec_size    = cur_size_next;
      res.elem_count  = cur_count_next;
      res.elem_stride = field_shift_next[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_axis_tlast)) begin
      byte_count    <= '0;
      field_shift   <= '0;
      hdr_fsize     <= '0;
      hdr_sections  <= '0;
      sections_left <= '0;
      entry_idx     <= '0;
      cur_type      <= '0;
      cur_flags     <= '0;
      cur_offset    <= '0;
      cur_size      <= '0;
      cur_count     <= '0;
      table_end     <= '0;
      first_error   <= ST_OK;
    end else if (accept) begin
      byte_count    <= byte_count_next;
      field_shift   <= field_shift_next;
      hdr_fsize     <= hdr_fsize_next;
      hdr_sections  <= hdr_sections_next;
      sections_left <= sections_left_next;
      entry_idx     <= entry_idx_next;
      cur_type      <= cur_type_next;
      cur_flags     <= cur_flags_next;
      cur_offset    <= cur_offset_next;
      cur_size      <= cur_size_next;
      cur_count     <= cur_count_next;
      table_end     <= table_end_next;
      first_error   <= first_error_next;
    end
  end

  // two-entry result buffer: output register plus skid
  result_t out_reg, skid_reg;
  logic    out_valid, skid_valid;
  logic    pop;

  assign push          = accept && (s_axis_tlast || have_desc);
  assign pop           = out_valid && m_axis_tready;
  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_reg <= skid_reg;
    end else if (push) begin
      if (!out_valid || pop) out_reg  <= res;
      else                   skid_reg <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_reg.kind;
  assign m_axis_tdata  = {4'd0, out_reg.section_total, out_reg.status,
                          out_reg.elem_stride, out_reg.elem_count, out_reg.sec_size,
                          out_reg.sec_offset, out_reg.sec_flags, out_reg.sec_type};

endmodule
